@@ rtl/core/fbp_pkg.sv @@
// shared types, constants and helpers of the flow bandwidth policer
`default_nettype none
package fbp_pkg;

    localparam int unsigned FLOW_ENTRIES_DEF = 256;
    localparam int unsigned THR_W = 16;
    localparam int unsigned WIN_W = 32;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned PROD_W = TIME_W + THR_W;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [THR_W-1:0] THR_RESET = 16'd1;
    localparam logic [WIN_W-1:0] WIN_RESET = 32'd1000000000;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [LEN_W-1:0] MIN_ETH = 16'd14;
    localparam logic [LEN_W-1:0] MIN_IP = 16'd34;
    localparam logic [LEN_W-1:0] MIN_UDP = 16'd42;
    localparam logic [LEN_W-1:0] MIN_TCP = 16'd54;
    localparam logic [1:0] L4_TCP = 2'd1;
    localparam logic [1:0] L4_UDP = 2'd2;
    localparam logic [3:0] MUL_LAST = 4'(THR_W - 1);

    typedef enum logic [1:0] {
        V_PASS  = 2'd0,
        V_DROP  = 2'd1,
        V_ABORT = 2'd2,
        V_TX    = 2'd3
    } t_verdict;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WINDOW    = 2'd1,
        CFG_PASS_TX   = 2'd2
    } t_cfg_reg;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CLASS = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_LAST  = 9'b000010000,
        S_EVAL  = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [63:0] now_ns;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [63:0] addr_key;
        logic [33:0] port_proto_key;
        logic [63:0] start_ns;
        logic [63:0] byte_count;
    } t_entry;

    typedef struct packed {
        logic     early;
        t_verdict verdict;
        logic [1:0] l4;
    } t_class;

    typedef struct packed {
        logic load;
        logic mem_clr;
        logic rd_en;
        logic cmp;
        logic scan_init;
        logic set_early;
        logic eval;
        logic write_fresh;
        logic mul_step;
        logic write_final;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic found;
        logic have_free;
        logic fresh;
        logic out_free;
    } t_dp_sts;

    function automatic t_class classify(input t_item it);
        t_class c;
        c.early = 1'b1;
        c.verdict = V_PASS;
        c.l4 = L4_TCP;
        if (it.frame_length == '0) begin
            c.verdict = V_ABORT;
        end else if (it.frame_length < MIN_ETH) begin
            c.verdict = V_DROP;
        end else if (it.ether_type != ETYPE_IPV4) begin
            c.verdict = V_PASS;
        end else if (it.frame_length < MIN_IP) begin
            c.verdict = V_DROP;
        end else if (it.ip_protocol == PROTO_UDP) begin
            c.l4 = L4_UDP;
            if (it.frame_length < MIN_UDP) c.verdict = V_DROP;
            else c.early = 1'b0;
        end else if (it.ip_protocol == PROTO_TCP) begin
            if (it.frame_length < MIN_TCP) c.verdict = V_DROP;
            else c.early = 1'b0;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/fbp_ifs.sv @@
// item and configuration channel interfaces of the flow bandwidth policer
`default_nettype none
interface fbp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] now_ns;
    modport source(output valid, frame_length, ether_type, ip_protocol, src_addr,
                   dst_addr, sport, dport, now_ns, input ready);
    modport sink(input valid, frame_length, ether_type, ip_protocol, src_addr,
                 dst_addr, sport, dport, now_ns, output ready);
endinterface

interface fbp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       flow_aged_out;
    modport source(output valid, verdict, flow_aged_out, input ready);
    modport sink(input valid, verdict, flow_aged_out, output ready);
endinterface

interface fbp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [31:0] data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fbp_ctrl.sv @@
// sequencing state machine of the flow bandwidth policer
`default_nettype none
module fbp_ctrl import fbp_pkg::*; #(
    parameter int unsigned FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    parameter int unsigned IDX_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_dp_sts          i_sts,
    output t_dp_cmd               o_cmd,
    output logic [IDX_W-1:0]      o_addr
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [3:0] r_mcnt, n_mcnt;
    logic r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_mcnt <= '0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_mcnt <= n_mcnt;
            r_pend <= (r_state == S_SCAN);
        end
    end

    assign o_addr = r_cnt;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_mcnt = r_mcnt;
        o_cmd = '0;
        o_cmd.cmp = r_pend;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_clr = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.early) begin
                    o_cmd.set_early = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_cnt = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt = '0;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.found && !i_sts.have_free) begin
                    n_state = S_DONE;
                end else if (i_sts.fresh) begin
                    o_cmd.write_fresh = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_mcnt = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == MUL_LAST) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write_final = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/fbp_dp.sv @@
// flow store, key match, rate check and result registers of the policer
`default_nettype none
module fbp_dp import fbp_pkg::*; #(
    parameter int unsigned FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    parameter int unsigned IDX_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [IDX_W-1:0] i_addr,
    output t_dp_sts               o_sts,
    input  wire t_item            i_item,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_addr,
    input  wire logic [31:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_verdict,
    output logic                  o_aged
);

    t_entry r_mem [FLOW_ENTRIES];
    t_entry r_rd;
    logic [IDX_W-1:0] r_rd_idx;

    t_item r_item;
    logic [THR_W-1:0] r_thr;
    logic [WIN_W-1:0] r_win;
    logic r_ptx;

    logic r_found, r_free_ok;
    logic [IDX_W-1:0] r_hit_idx, r_free_idx, r_tgt;
    logic [63:0] r_start, r_bytes, r_delta, r_num;
    logic [PROD_W-1:0] r_prod, r_mcand;
    logic [THR_W-1:0] r_mplier;
    t_verdict r_res;
    logic r_res_aged;
    logic r_ov;

    t_class w_cls;
    t_verdict w_accept;
    logic [63:0] w_akey;
    logic [33:0] w_pkey;
    logic [IDX_W-1:0] w_tgt, w_wr_addr;
    t_entry w_wr;
    logic w_we, w_drop, w_aged;

    assign w_cls = classify(r_item);
    assign w_accept = r_ptx ? V_TX : V_PASS;
    assign w_akey = {r_item.src_addr, r_item.dst_addr};
    assign w_pkey = {r_item.sport, r_item.dport, w_cls.l4};
    assign w_tgt = r_found ? r_hit_idx : r_free_idx;
    assign w_drop = (r_thr == '0) || ((r_delta != '0) && ({16'd0, r_num} >= r_prod));
    assign w_aged = (r_delta >= {32'd0, r_win});

    assign o_sts.early = w_cls.early;
    assign o_sts.found = r_found;
    assign o_sts.have_free = r_free_ok;
    assign o_sts.fresh = !r_found || (r_bytes == '0);
    assign o_sts.out_free = !r_ov || i_out_ready;

    always_comb begin
        w_we = i_cmd.mem_clr || i_cmd.write_fresh || i_cmd.write_final;
        w_wr_addr = r_tgt;
        w_wr = '0;
        if (i_cmd.mem_clr) begin
            w_wr_addr = i_addr;
        end else if (i_cmd.write_fresh) begin
            w_wr_addr = w_tgt;
            w_wr = {1'b1, w_akey, w_pkey, r_item.now_ns, {48'd0, r_item.frame_length}};
        end else begin
            w_wr.valid = !w_aged;
            w_wr.addr_key = w_akey;
            w_wr.port_proto_key = w_pkey;
            w_wr.start_ns = r_start;
            w_wr.byte_count = (w_aged || w_drop) ? r_bytes
                            : r_bytes + {48'd0, r_item.frame_length};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wr_addr] <= w_wr;
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_addr];
            r_rd_idx <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_win <= WIN_RESET;
            r_ptx <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_WINDOW:    r_win <= i_cfg_data;
                    CFG_PASS_TX:   r_ptx <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.scan_init) begin
            r_found <= 1'b0;
            r_free_ok <= 1'b0;
        end
        if (i_cmd.cmp) begin
            if (r_rd.valid) begin
                if (!r_found && r_rd.addr_key == w_akey && r_rd.port_proto_key == w_pkey) begin
                    r_found <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_start <= r_rd.start_ns;
                    r_bytes <= r_rd.byte_count;
                end
            end else if (!r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
        if (i_cmd.set_early) begin
            r_res <= w_cls.verdict;
            r_res_aged <= 1'b0;
        end
        if (i_cmd.eval) begin
            r_tgt <= w_tgt;
            r_delta <= r_item.now_ns - r_start;
            r_num <= (r_bytes + {48'd0, r_item.frame_length}) << 3;
            r_prod <= '0;
            r_mcand <= {16'd0, r_item.now_ns - r_start};
            r_mplier <= r_thr;
            r_res <= (!r_found && !r_free_ok) ? V_ABORT : w_accept;
            r_res_aged <= 1'b0;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) r_prod <= r_prod + r_mcand;
            r_mcand <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        if (i_cmd.write_final) begin
            r_res <= w_drop ? V_DROP : w_accept;
            r_res_aged <= w_aged;
        end
        if (i_cmd.out_load) begin
            o_verdict <= r_res;
            o_aged <= r_res_aged;
        end
    end

    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

@@ rtl/core/flow_bandwidth_policer.sv @@
// top level of the flow bandwidth policer
// Polices TCP and UDP flows keyed on the IPv4 five-tuple and gives one verdict per packet
// item. After reset the flow store is cleared entry by entry, during which no item is
// taken. Packets settled by length or header checks skip the flow store; tracked flows
// are found by a flow store search that reads one entry per cycle through the single
// memory read port, and a rate check of a flow that is neither new nor fresh adds 16
// shift-add steps of the threshold times age product. A stalled output holds back the
// next item. A finished verdict is held in an output register until taken; configuration
// writes are accepted in every cycle.
`default_nettype none
module flow_bandwidth_policer import fbp_pkg::*; #(
    parameter int unsigned FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fbp_in_if.sink    i_in,
    fbp_cfg_if.sink   i_cfg,
    fbp_out_if.source o_out
);

    localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic [IDX_W-1:0] w_addr;
    t_item w_item;

    assign w_item = {i_in.frame_length, i_in.ether_type, i_in.ip_protocol, i_in.src_addr,
                     i_in.dst_addr, i_in.sport, i_in.dport, i_in.now_ns};
    assign i_cfg.ready = 1'b1;

    fbp_ctrl #(
        .FLOW_ENTRIES(FLOW_ENTRIES),
        .IDX_W(IDX_W)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_sts(w_sts),
        .o_cmd(w_cmd),
        .o_addr(w_addr)
    );

    fbp_dp #(
        .FLOW_ENTRIES(FLOW_ENTRIES),
        .IDX_W(IDX_W)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(w_cmd),
        .i_addr(w_addr),
        .o_sts(w_sts),
        .i_item(w_item),
        .i_cfg_we(i_cfg.valid),
        .i_cfg_addr(i_cfg.addr),
        .i_cfg_data(i_cfg.data),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_verdict(o_out.verdict),
        .o_aged(o_out.flow_aged_out)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_fbp_types.sv @@
// item and verdict record types used by the flow bandwidth policer testbench
`timescale 1ns / 100ps
package tb_fbp_types;
    import fbp_pkg::*;

    typedef struct {
        t_verdict verdict;
        logic     aged;
    } t_outcome;

    typedef struct {
        logic          is_cfg;
        t_cfg_reg      reg_idx;
        logic [31:0]   reg_data;
        t_item         pkt;
    } t_stim;
endpackage

@@ tb/sv/tb_flow_bandwidth_policer.sv @@
// testbench of the flow bandwidth policer: random and directed packets checked against a predictor
`timescale 1ns / 100ps
module tb_flow_bandwidth_policer;
    import fbp_pkg::*;
    import tb_fbp_types::*;

    localparam int unsigned NFLOW = FLOW_ENTRIES_DEF;
    localparam int unsigned QUIET_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    fbp_in_if  pkt_if();
    fbp_cfg_if cfg_if();
    fbp_out_if res_if();

    flow_bandwidth_policer u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(pkt_if.sink),
        .i_cfg(cfg_if.sink),
        .o_out(res_if.source)
    );

    // predictor state
    logic        flow_vld   [NFLOW];
    logic [63:0] flow_akey  [NFLOW];
    logic [33:0] flow_pkey  [NFLOW];
    logic [63:0] flow_start [NFLOW];
    logic [63:0] flow_bytes [NFLOW];
    logic [15:0] thr_cfg;
    logic [31:0] win_cfg;
    logic        ptx_cfg;

    t_stim       pending_q[$];
    t_outcome    verdict_q[$];
    int          fails;
    int          quiet_cycles;
    bit          stim_done;
    bit          drv_idle_ok;
    bit          snk_idle_ok;
    int          drv_gap;
    int          snk_gap;
    bit          hold_flag;

    // predictor: policing decision for one accepted packet
    function automatic t_outcome police_packet(input t_item p);
        t_outcome    r;
        t_verdict    acc;
        logic [1:0]  l4;
        logic [63:0] akey;
        logic [33:0] pkey;
        logic [63:0] delta;
        logic [63:0] rate;
        int          hit;
        int          free_idx;
        bit          aged;
        acc = ptx_cfg ? V_TX : V_PASS;
        r.aged = 1'b0;
        r.verdict = V_PASS;
        hit = -1;
        free_idx = -1;
        aged = 0;
        if (p.frame_length == 0) begin
            r.verdict = V_ABORT;
            return r;
        end
        if (p.frame_length < 14) begin
            r.verdict = V_DROP;
            return r;
        end
        if (p.ether_type != ETYPE_IPV4) return r;
        if (p.frame_length < 34) begin
            r.verdict = V_DROP;
            return r;
        end
        if (p.ip_protocol == PROTO_UDP) begin
            if (p.frame_length < 42) begin
                r.verdict = V_DROP;
                return r;
            end
            l4 = L4_UDP;
        end else if (p.ip_protocol == PROTO_TCP) begin
            if (p.frame_length < 54) begin
                r.verdict = V_DROP;
                return r;
            end
            l4 = L4_TCP;
        end else begin
            return r;
        end
        akey = {p.src_addr, p.dst_addr};
        pkey = {p.sport, p.dport, l4};
        for (int i = 0; i < NFLOW; i++) begin
            if (flow_vld[i]) begin
                if (hit < 0 && flow_akey[i] == akey && flow_pkey[i] == pkey) hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit < 0) begin
            if (free_idx < 0) begin
                r.verdict = V_ABORT;
                return r;
            end
            hit = free_idx;
            flow_vld[hit] = 1'b1;
            flow_akey[hit] = akey;
            flow_pkey[hit] = pkey;
            flow_start[hit] = '0;
            flow_bytes[hit] = '0;
        end
        if (flow_bytes[hit] == 0) begin
            flow_start[hit] = p.now_ns;
            flow_bytes[hit] = 64'(p.frame_length);
            r.verdict = acc;
            return r;
        end
        delta = p.now_ns - flow_start[hit];
        rate = (delta == 0) ? 64'd0 : ((flow_bytes[hit] + 64'(p.frame_length)) * 64'd8) / delta;
        if (delta >= 64'(win_cfg)) begin
            flow_vld[hit] = 1'b0;
            aged = 1;
        end
        r.aged = aged;
        if (rate >= 64'(thr_cfg)) begin
            r.verdict = V_DROP;
            return r;
        end
        if (!aged) flow_bytes[hit] = flow_bytes[hit] + 64'(p.frame_length);
        r.verdict = acc;
        return r;
    endfunction

    function automatic t_item make_pkt(input logic [15:0] len, input logic [15:0] et,
                                       input logic [7:0] pr, input logic [31:0] sa,
                                       input logic [31:0] da, input logic [15:0] sp,
                                       input logic [15:0] dp, input logic [63:0] t);
        t_item p;
        p.frame_length = len;
        p.ether_type = et;
        p.ip_protocol = pr;
        p.src_addr = sa;
        p.dst_addr = da;
        p.sport = sp;
        p.dport = dp;
        p.now_ns = t;
        return p;
    endfunction

    task automatic push_pkt(input t_item p);
        t_stim s;
        s.is_cfg = 1'b0;
        s.reg_idx = CFG_THRESHOLD;
        s.reg_data = '0;
        s.pkt = p;
        pending_q.push_back(s);
    endtask

    task automatic push_cfg(input t_cfg_reg idx, input logic [31:0] d);
        t_stim s;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_data = d;
        s.pkt = '0;
        pending_q.push_back(s);
    endtask

    task automatic random_pkt(input int pool, input logic [63:0] t);
        logic [15:0] len;
        logic [7:0]  pr;
        logic [15:0] et;
        int          k;
        int          sel;
        k = $urandom_range(pool - 1);
        sel = $urandom_range(99);
        et = ETYPE_IPV4;
        pr = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        len = 16'($urandom_range(1500, 54));
        if (sel < 4) len = 16'($urandom_range(53));
        else if (sel < 8) et = 16'($urandom);
        else if (sel < 12) pr = 8'($urandom);
        else if (sel < 15) len = 16'($urandom);
        if (k == 0) begin
            push_pkt(make_pkt(len, et, pr, $urandom, $urandom, 16'($urandom),
                              16'($urandom), t));
        end else begin
            push_pkt(make_pkt(len, et, pr, 32'h0a000000 + k, 32'hc0a80000 ^ (k * 77),
                              16'(1000 + k), 16'(80 + k), t));
        end
    endtask

    task automatic random_phase(input int n, input int pool, input int step_max,
                                input logic [63:0] t0);
        logic [63:0] t;
        t = t0;
        for (int i = 0; i < n; i++) begin
            t = t + 64'($urandom_range(step_max));
            random_pkt(pool, t);
        end
    endtask

    // a config write marker: the driver waits for drain before a write
    initial begin
        logic [63:0] t;
        push_cfg(CFG_THRESHOLD, 32'd1);
        // length and header checks
        push_pkt(make_pkt(16'd0, ETYPE_IPV4, PROTO_TCP, '1, '1, '1, '1, '1));
        push_pkt(make_pkt(16'd13, ETYPE_IPV4, PROTO_TCP, 1, 2, 3, 4, 0));
        push_pkt(make_pkt(16'd14, 16'h86dd, PROTO_TCP, 1, 2, 3, 4, 0));
        push_pkt(make_pkt(16'hffff, 16'hffff, 8'hff, '1, '1, '1, '1, '1));
        push_pkt(make_pkt(16'd33, ETYPE_IPV4, PROTO_UDP, 1, 2, 3, 4, 0));
        push_pkt(make_pkt(16'd41, ETYPE_IPV4, PROTO_UDP, 1, 2, 3, 4, 0));
        push_pkt(make_pkt(16'd53, ETYPE_IPV4, PROTO_TCP, 1, 2, 3, 4, 0));
        push_pkt(make_pkt(16'd34, ETYPE_IPV4, 8'd1, 1, 2, 3, 4, 0));
        // one udp flow: fresh, zero delta, rate under and over threshold, aging
        push_pkt(make_pkt(16'd42, ETYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 64'd100));
        push_pkt(make_pkt(16'd42, ETYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 64'd100));
        push_pkt(make_pkt(16'd42, ETYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 64'd110));
        push_pkt(make_pkt(16'd42, ETYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 64'd10000));
        push_pkt(make_pkt(16'd42, ETYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0,
                          64'd2000000000));
        // tcp flow with maximum fields and time wrap
        push_pkt(make_pkt(16'hffff, ETYPE_IPV4, PROTO_TCP, '1, '1, '1, '1, '1));
        push_pkt(make_pkt(16'hffff, ETYPE_IPV4, PROTO_TCP, '1, '1, '1, '1, 64'd500));
        push_cfg(CFG_PASS_TX, 32'd1);
        push_cfg(CFG_THRESHOLD, 32'd65535);
        push_cfg(CFG_WINDOW, 32'hffffffff);
        push_pkt(make_pkt(16'd54, ETYPE_IPV4, PROTO_TCP, 5, 6, 7, 8, 64'd1000));
        push_pkt(make_pkt(16'd54, ETYPE_IPV4, PROTO_TCP, 5, 6, 7, 8, 64'd1001));
        push_pkt(make_pkt(16'd54, ETYPE_IPV4, PROTO_TCP, 5, 6, 7, 8, 64'd1001));
        push_cfg(CFG_THRESHOLD, 32'd0);
        push_cfg(CFG_WINDOW, 32'd1);
        push_pkt(make_pkt(16'd54, ETYPE_IPV4, PROTO_TCP, 5, 6, 7, 8, 64'd1001));
        push_pkt(make_pkt(16'd54, ETYPE_IPV4, PROTO_TCP, 5, 6, 7, 8, 64'd1005));
        // random phases over several settings
        t = 64'd5000;
        push_cfg(CFG_THRESHOLD, 32'd2);
        push_cfg(CFG_WINDOW, 32'd3000);
        push_cfg(CFG_PASS_TX, 32'd0);
        random_phase(30, 24, 300, t);
        push_cfg(CFG_THRESHOLD, 32'($urandom_range(8, 1)));
        push_cfg(CFG_WINDOW, 32'd1000000000);
        push_cfg(CFG_PASS_TX, 32'd1);
        random_phase(30, 40, 2000, 64'd1000000);
        // a burst of distinct flows fills the store so allocation aborts
        push_cfg(CFG_THRESHOLD, 32'd65535);
        push_cfg(CFG_WINDOW, 32'hffffffff);
        for (int i = 0; i < NFLOW + 4; i++)
            push_pkt(make_pkt(16'd60, ETYPE_IPV4, PROTO_UDP, 32'hac100000 + i, 32'h1,
                              16'(i), 16'd53, 64'd10));
        push_cfg(CFG_WINDOW, 32'd1);
        push_cfg(CFG_THRESHOLD, 32'd0);
        random_phase(30, 8, 1 << 20, 64'hffff_ffff_ff00_0000);
        push_cfg(CFG_THRESHOLD, 32'($urandom_range(65535)));
        push_cfg(CFG_WINDOW, 32'($urandom));
        push_cfg(CFG_PASS_TX, 32'($urandom_range(1)));
        random_phase(30, 16, 1 << 24, 64'($urandom));
        stim_done = 1'b1;
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin
        for (int i = 0; i < NFLOW; i++) begin
            flow_vld[i] = 1'b0;
            flow_akey[i] = '0;
            flow_pkey[i] = '0;
            flow_start[i] = '0;
            flow_bytes[i] = '0;
        end
        thr_cfg = THR_RESET;
        win_cfg = WIN_RESET;
        ptx_cfg = 1'b0;
        fails = 0;
        hold_flag = 1'b0;
        drv_idle_ok = 1'b1;
        snk_idle_ok = 1'b1;
        drv_gap = 0;
        snk_gap = 0;
        quiet_cycles = 0;
        pkt_if.valid = 1'b0;
        pkt_if.frame_length = '0;
        pkt_if.ether_type = '0;
        pkt_if.ip_protocol = '0;
        pkt_if.src_addr = '0;
        pkt_if.dst_addr = '0;
        pkt_if.sport = '0;
        pkt_if.dport = '0;
        pkt_if.now_ns = '0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = CFG_THRESHOLD;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
    end

    // driver: packets on the item channel, register writes only once drained
    int settle;
    initial settle = 0;

    function automatic t_item pkt_if_item();
        return make_pkt(pkt_if.frame_length, pkt_if.ether_type, pkt_if.ip_protocol,
                        pkt_if.src_addr, pkt_if.dst_addr, pkt_if.sport,
                        pkt_if.dport, pkt_if.now_ns);
    endfunction

    bit pkt_taken;
    bit cfg_taken;
    always @(posedge i_clk) begin
        pkt_taken = i_rst_n && pkt_if.valid && pkt_if.ready;
        cfg_taken = i_rst_n && cfg_if.valid && cfg_if.ready;
        if (pkt_taken) verdict_q.push_back(police_packet(pkt_if_item()));
        if (cfg_taken) begin
            case (cfg_if.addr)
                CFG_THRESHOLD: thr_cfg = cfg_if.data[15:0];
                CFG_WINDOW:    win_cfg = cfg_if.data;
                CFG_PASS_TX:   ptx_cfg = cfg_if.data[0];
                default: ;
            endcase
        end
    end

    always @(negedge i_clk) begin
        bit busy;
        bit last_part;
        busy = (pkt_if.valid && !pkt_taken) || (cfg_if.valid && !cfg_taken);
        last_part = stim_done && pending_q.size() < 60;
        if (i_rst_n && !busy) begin
            if (drv_gap > 0) begin
                drv_gap--;
                pkt_if.valid <= 1'b0;
                cfg_if.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                if (pending_q[0].is_cfg) begin
                    pkt_if.valid <= 1'b0;
                    if (verdict_q.size() == 0 && !(pkt_if.valid) && settle >= 300) begin
                        cfg_if.addr <= pending_q[0].reg_idx;
                        cfg_if.data <= pending_q[0].reg_data;
                        cfg_if.valid <= 1'b1;
                        void'(pending_q.pop_front());
                        settle = 0;
                    end else begin
                        cfg_if.valid <= 1'b0;
                        settle = (verdict_q.size() == 0) ? settle + 1 : 0;
                    end
                end else if (hold_flag) begin
                    pkt_if.valid <= 1'b0;
                    cfg_if.valid <= 1'b0;
                    if (verdict_q.size() == 0) hold_flag = 1'b0;
                end else begin
                    cfg_if.valid <= 1'b0;
                    pkt_if.frame_length <= pending_q[0].pkt.frame_length;
                    pkt_if.ether_type <= pending_q[0].pkt.ether_type;
                    pkt_if.ip_protocol <= pending_q[0].pkt.ip_protocol;
                    pkt_if.src_addr <= pending_q[0].pkt.src_addr;
                    pkt_if.dst_addr <= pending_q[0].pkt.dst_addr;
                    pkt_if.sport <= pending_q[0].pkt.sport;
                    pkt_if.dport <= pending_q[0].pkt.dport;
                    pkt_if.now_ns <= pending_q[0].pkt.now_ns;
                    pkt_if.valid <= 1'b1;
                    void'(pending_q.pop_front());
                    if (!last_part && $urandom_range(9) == 0) drv_gap = $urandom_range(17, 1);
                    if ($urandom_range(63) == 0) hold_flag = 1'b1;
                end
            end else begin
                pkt_if.valid <= 1'b0;
                cfg_if.valid <= 1'b0;
            end
        end
    end

    // result sink with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (!(stim_done && pending_q.size() < 60) && $urandom_range(7) == 0)
                snk_gap = $urandom_range(17, 1);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict %0d aged %0d", $realtime,
                         res_if.verdict, res_if.flow_aged_out);
                fails++;
            end else begin
                want = verdict_q.pop_front();
                if (res_if.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $realtime,
                             want.verdict, res_if.verdict);
                    fails++;
                end
                if (res_if.flow_aged_out !== want.aged) begin
                    $display("%0t: aged flag expected %0d actual %0d", $realtime,
                             want.aged, res_if.flow_aged_out);
                    fails++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge i_clk) begin
        if ((pkt_if.valid && pkt_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (res_if.valid && res_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_flow_bandwidth_policer NOT OK");
                $finish;
            end else if (stim_done && pending_q.size() == 0 && verdict_q.size() == 0 &&
                         !pkt_if.valid && !cfg_if.valid) begin
                repeat (300) @(posedge i_clk);
                if (fails == 0 && verdict_q.size() == 0)
                    $display("tb_flow_bandwidth_policer OK");
                else
                    $display("tb_flow_bandwidth_policer NOT OK");
                $finish;
            end
        end
    end
endmodule
